@@ rtl/tea_pkg.sv @@
package tea_pkg;

    localparam int unsigned ROUNDS_DEF = 32;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BLOCK_W    = 64;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    localparam logic [CFG_IDX_W-1:0] KEY_IDX_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX_3 = 8'd3;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_key;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
    } t_stage;

    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

@@ rtl/tea_cell.sv @@
module tea_cell #(
    parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEF,
    parameter int unsigned RND    = 0,
    parameter bit          HALF   = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tea_pkg::t_key   i_key,
    input  logic            i_valid,
    input  tea_pkg::t_stage i_stage,
    output logic            o_valid,
    output tea_pkg::t_stage o_stage
);

    localparam longint unsigned SUM_ENC_FULL =
        longint'(tea_pkg::DELTA) * longint'(RND + 1);
    localparam longint unsigned SUM_DEC_FULL =
        longint'(tea_pkg::DELTA) * longint'(ROUNDS - RND);
    localparam logic [tea_pkg::WORD_W-1:0] SUM_ENC = SUM_ENC_FULL[tea_pkg::WORD_W-1:0];
    localparam logic [tea_pkg::WORD_W-1:0] SUM_DEC = SUM_DEC_FULL[tea_pkg::WORD_W-1:0];

    logic                        r_valid;
    tea_pkg::t_stage             r_stage;
    tea_pkg::t_stage             n_stage;
    logic                        upd_hi;
    logic [tea_pkg::WORD_W-1:0]  sum;
    logic [tea_pkg::WORD_W-1:0]  x;
    logic [tea_pkg::WORD_W-1:0]  ka;
    logic [tea_pkg::WORD_W-1:0]  kb;
    logic [tea_pkg::WORD_W-1:0]  m;
    logic [tea_pkg::WORD_W-1:0]  step;

    // Encryption updates the high half first, decryption the low half first.
    always_comb begin
        upd_hi = HALF ? i_stage.mode : !i_stage.mode;
        sum    = i_stage.mode ? SUM_DEC : SUM_ENC;
        x      = upd_hi ? i_stage.lo : i_stage.hi;
        ka     = upd_hi ? i_key.k0 : i_key.k2;
        kb     = upd_hi ? i_key.k1 : i_key.k3;
        m      = tea_pkg::mix(x, sum, ka, kb);
        step   = i_stage.mode ? (~m + 32'd1) : m;
        n_stage = i_stage;
        if (upd_hi) begin
            n_stage.hi = i_stage.hi + step;
        end else begin
            n_stage.lo = i_stage.lo + step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

@@ rtl/tea_block_cipher_core.sv @@
// TEA block cipher core. An item is a 64-bit block with a mode bit (0 encrypt,
// 1 decrypt) and is taken on any cycle where start is high; busy is always low,
// so one block can enter every clock cycle. The result appears on o_block_out
// with o_valid high for exactly one cycle, once the block has passed through
// the chain of half-round cells, each of which registers it. The receiver cannot
// stall the core, so o_valid must be sampled on the cycle it is high. The four
// key words are written through the configuration channel, which is always
// ready; they must only be changed while no block is in flight.
module tea_block_cipher_core #(
    parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [tea_pkg::BLOCK_W-1:0]     i_block_in,
    output logic                            o_valid,
    output logic [tea_pkg::BLOCK_W-1:0]     o_block_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tea_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]      i_cfg_data
);

    localparam int unsigned NCELLS = 2 * ROUNDS;

    tea_pkg::t_key   r_key;
    logic            w_valid [0:NCELLS];
    tea_pkg::t_stage w_stage [0:NCELLS];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tea_pkg::KEY_IDX_0: r_key.k0 <= i_cfg_data;
                tea_pkg::KEY_IDX_1: r_key.k1 <= i_cfg_data;
                tea_pkg::KEY_IDX_2: r_key.k2 <= i_cfg_data;
                tea_pkg::KEY_IDX_3: r_key.k3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_valid[0]      = start && !busy;
    assign w_stage[0].mode = i_mode;
    assign w_stage[0].hi   = i_block_in[tea_pkg::BLOCK_W-1:tea_pkg::WORD_W];
    assign w_stage[0].lo   = i_block_in[tea_pkg::WORD_W-1:0];

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        tea_cell #(
            .ROUNDS (ROUNDS),
            .RND    (g / 2),
            .HALF   (1'(g % 2))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    assign o_valid     = w_valid[NCELLS];
    assign o_block_out = {w_stage[NCELLS].hi, w_stage[NCELLS].lo};

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##NCELLS o_valid)
        else $error("accepted item did not come out after the pipeline latency");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe high right after reset");

    a_key0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == tea_pkg::KEY_IDX_0)
        |=> r_key.k0 == $past(i_cfg_data))
        else $error("key word 0 not updated by configuration write");

    a_key3_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == tea_pkg::KEY_IDX_3)
        |=> r_key.k3 == $past(i_cfg_data))
        else $error("key word 3 not updated by configuration write");

endmodule
